// ===== src/aptq_pkg.sv =====
// ----------------------------------------------------------------------------
// aptq_pkg
// Shared types and codes of the aging priority task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package aptq_pkg;

    localparam int ID_W      = 16;
    localparam int BASE_W    = 10;
    localparam int TIME_W    = 16;
    localparam int ORDER_W   = 16;
    localparam int RATE_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int STATUS_W  = 2;
    localparam int PRIO_W    = 26;   // exact aged priority, signed
    localparam int OUT_PRIO_W = 24;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_AGING_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOW_TIME   = 1'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [RATE_W-1:0] AGING_RATE_RST = 8'd26;

    // one memory word per slot
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BASE_W-1:0]  base;
        logic [TIME_W-1:0]  created;
        logic [ORDER_W-1:0] order;
    } t_slot;

    // control that rides along the scan pipeline
    typedef struct packed {
        logic live;   // stage holds a scan step
        logic act;    // slot was occupied
        logic last;   // final slot of the scan
    } t_scan_tag;

    typedef struct packed {
        t_scan_tag                 tag;
        logic [ID_W-1:0]           id;
        logic signed [PRIO_W-1:0]  prio;
        logic [ORDER_W-1:0]        sen;
    } t_cand;

endpackage

`default_nettype wire

// ===== src/aptq_aging.sv =====
// ----------------------------------------------------------------------------
// aptq_aging
// Scan stage: aged priority and seniority of one slot, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module aptq_aging #(
    parameter int IDX_W = 5
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire aptq_pkg::t_scan_tag               i_tag,
    input  wire logic [IDX_W-1:0]                  i_idx,
    input  wire aptq_pkg::t_slot                   i_slot,
    input  wire logic [aptq_pkg::RATE_W-1:0]       i_rate,
    input  wire logic [aptq_pkg::TIME_W-1:0]       i_now,
    input  wire logic [aptq_pkg::ORDER_W-1:0]      i_insert_cnt,
    output aptq_pkg::t_cand                        o_cand,
    output logic [IDX_W-1:0]                       o_idx
);

    localparam int PW = aptq_pkg::PRIO_W;
    localparam int TW = aptq_pkg::TIME_W;

    logic signed [TW:0]   w_diff;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_base;
    aptq_pkg::t_cand      r_cand;
    logic [IDX_W-1:0]     r_idx;

    always_comb begin
        w_diff = $signed({1'b0, i_now}) - $signed({1'b0, i_slot.created});
        w_prod = PW'(w_diff) * $signed(PW'({1'b0, i_rate}));
        w_base = $signed(PW'({i_slot.base, 8'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.tag <= '0;
        end else begin
            r_cand.tag <= i_tag;
        end
        r_cand.id   <= i_slot.id;
        r_cand.prio <= w_base + w_prod;
        // modular age: larger means inserted earlier
        r_cand.sen  <= i_insert_cnt - i_slot.order;
        r_idx       <= i_idx;
    end

    assign o_cand = r_cand;
    assign o_idx  = r_idx;

endmodule

`default_nettype wire

// ===== src/aging_priority_task_queue.sv =====
// ----------------------------------------------------------------------------
// aging_priority_task_queue
// Slot-based task queue; pop returns the task of highest aged priority.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one operation per beat:
// a push stores task id, base priority and creation time in the lowest free
// slot; a pop removes the slot with the highest
//     base*256 + (now - created) * aging_rate
// (ties to the earliest inserted). Every beat yields one result beat on the
// output channel (o_out_valid / i_out_ready): status, popped id, priority.
// Config writes (i_cfg_we) set aging_rate (index 0) and now_time (index 1).
// A push walks the slot valid bits one per cycle from slot 0. A pop
// streams every slot through the single read port of the slot memory,
// one slot per cycle, behind a two-stage priority/compare pipe.
// The result sits in an output register; while the receiver stalls the
// next beat is still accepted and worked on, and it waits only at its own
// result hand-off. Reset empties the queue (valid bits clear at once, no
// memory sweep), restores aging_rate to 26 and now_time to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_priority_task_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [aptq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [aptq_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_operation,
    input  wire logic [aptq_pkg::ID_W-1:0]           i_task_id,
    input  wire logic [aptq_pkg::BASE_W-1:0]         i_base_priority,
    input  wire logic [aptq_pkg::TIME_W-1:0]         i_created_time,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [aptq_pkg::STATUS_W-1:0]            o_status,
    output logic [aptq_pkg::ID_W-1:0]                o_out_task_id,
    output logic [aptq_pkg::OUT_PRIO_W-1:0]          o_out_priority
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PW    = aptq_pkg::PRIO_W;
    localparam int OPW   = aptq_pkg::OUT_PRIO_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP_SCAN,
        S_POP_WAIT,
        S_POP_FIN,
        S_RESULT
    } t_state;

    t_state                              r_state;
    logic [aptq_pkg::RATE_W-1:0]         r_aging_rate;
    logic [aptq_pkg::TIME_W-1:0]         r_now_time;
    logic [aptq_pkg::ORDER_W-1:0]        r_insert_cnt;
    logic [QUEUE_DEPTH-1:0]              r_valid;
    logic [IDX_W-1:0]                    r_idx;

    logic                                r_op;
    aptq_pkg::t_slot                     r_push_slot;

    aptq_pkg::t_slot                     r_mem [QUEUE_DEPTH];
    aptq_pkg::t_slot                     r_rd_slot;
    aptq_pkg::t_scan_tag                 r_rd_tag;
    logic [IDX_W-1:0]                    r_rd_idx;

    aptq_pkg::t_cand                     w_cand;
    logic [IDX_W-1:0]                    w_cand_idx;

    logic                                r_best_found;
    logic signed [PW-1:0]                r_best_prio;
    logic [aptq_pkg::ORDER_W-1:0]        r_best_sen;
    logic [aptq_pkg::ID_W-1:0]           r_best_id;
    logic [IDX_W-1:0]                    r_best_idx;
    logic                                n_take;

    logic [aptq_pkg::STATUS_W-1:0]       r_res_status;
    logic [aptq_pkg::ID_W-1:0]           r_res_id;
    logic [OPW-1:0]                      r_res_prio;
    logic [OPW-1:0]                      w_sat_prio;

    logic                                r_out_valid;
    logic [aptq_pkg::STATUS_W-1:0]       r_out_status;
    logic [aptq_pkg::ID_W-1:0]           r_out_id;
    logic [OPW-1:0]                      r_out_prio;

    logic                                w_mem_we;
    logic                                w_in_beat;
    logic                                w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_mem_we   = (r_state == S_PUSH) && !r_valid[r_idx];

    // slot memory: one write port for push, one registered read for scan
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= r_push_slot;
        end
        r_rd_slot <= r_mem[r_idx];
    end

    aptq_aging #(
        .IDX_W (IDX_W)
    ) u_aging (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (r_rd_tag),
        .i_idx        (r_rd_idx),
        .i_slot       (r_rd_slot),
        .i_rate       (r_aging_rate),
        .i_now        (r_now_time),
        .i_insert_cnt (r_insert_cnt),
        .o_cand       (w_cand),
        .o_idx        (w_cand_idx)
    );

    // running best; ties go to the larger seniority
    always_comb begin
        n_take = w_cand.tag.live && w_cand.tag.act &&
                 (!r_best_found ||
                  ($signed(w_cand.prio) > r_best_prio) ||
                  (($signed(w_cand.prio) == r_best_prio) && (w_cand.sen > r_best_sen)));
    end

    // clamp to 0..2^24-1
    always_comb begin
        if (r_best_prio[PW-1]) begin
            w_sat_prio = '0;
        end else if (|r_best_prio[PW-2:OPW]) begin
            w_sat_prio = '1;
        end else begin
            w_sat_prio = r_best_prio[OPW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_aging_rate <= aptq_pkg::AGING_RATE_RST;
            r_now_time   <= '0;
            r_insert_cnt <= '0;
            r_valid      <= '0;
            r_idx        <= '0;
            r_rd_tag     <= '0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    aptq_pkg::CFG_AGING_RATE:
                        r_aging_rate <= i_cfg_data[aptq_pkg::RATE_W-1:0];
                    aptq_pkg::CFG_NOW_TIME:
                        r_now_time <= i_cfg_data[aptq_pkg::TIME_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            r_rd_tag <= '0;

            if (n_take) begin
                r_best_found <= 1'b1;
                r_best_prio  <= $signed(w_cand.prio);
                r_best_sen   <= w_cand.sen;
                r_best_id    <= w_cand.id;
                r_best_idx   <= w_cand_idx;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_op                <= i_operation;
                        r_push_slot.id      <= i_task_id;
                        r_push_slot.base    <= i_base_priority;
                        r_push_slot.created <= i_created_time;
                        r_push_slot.order   <= r_insert_cnt;
                        r_idx               <= '0;
                        r_best_found        <= 1'b0;
                        r_state <= (i_operation == aptq_pkg::OP_PUSH) ? S_PUSH : S_POP_SCAN;
                    end
                end
                S_PUSH: begin
                    r_res_id   <= '0;
                    r_res_prio <= '0;
                    if (!r_valid[r_idx]) begin
                        r_valid[r_idx] <= 1'b1;
                        r_insert_cnt   <= r_insert_cnt + 1'b1;
                        r_res_status   <= aptq_pkg::STATUS_OK;
                        r_state        <= S_RESULT;
                    end else if (r_idx == LAST_IDX) begin
                        r_res_status <= aptq_pkg::STATUS_FULL;
                        r_state      <= S_RESULT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_POP_SCAN: begin
                    r_rd_tag.live <= 1'b1;
                    r_rd_tag.act  <= r_valid[r_idx];
                    r_rd_tag.last <= (r_idx == LAST_IDX);
                    r_rd_idx      <= r_idx;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_POP_WAIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_POP_WAIT: begin
                    if (w_cand.tag.live && w_cand.tag.last) begin
                        r_state <= S_POP_FIN;
                    end
                end
                S_POP_FIN: begin
                    if (r_best_found) begin
                        r_valid[r_best_idx] <= 1'b0;
                        r_res_status        <= aptq_pkg::STATUS_OK;
                        r_res_id            <= r_best_id;
                        r_res_prio          <= w_sat_prio;
                    end else begin
                        r_res_status <= aptq_pkg::STATUS_EMPTY;
                        r_res_id     <= '0;
                        r_res_prio   <= '0;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_id     <= r_res_id;
                        r_out_prio   <= r_res_prio;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_task_id  = r_out_id;
    assign o_out_priority = r_out_prio;

    // scan pipe is drained whenever a new beat can be taken
    a_pipe_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_tag.live && !w_cand.tag.live))
        else $error("scan pipeline busy while idle");

    a_pop_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_FIN && r_best_found) |=> !r_valid[$past(r_best_idx)])
        else $error("popped slot still marked valid");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && !r_valid[r_idx])
        |=> (r_insert_cnt == aptq_pkg::ORDER_W'($past(r_insert_cnt) + 1'b1)))
        else $error("insert counter did not advance on push");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != aptq_pkg::STATUS_OK) && r_op == aptq_pkg::OP_POP)
        |-> (o_out_task_id == '0 && o_out_priority == '0))
        else $error("empty pop returned nonzero payload");

endmodule

`default_nettype wire

// ===== sim/aging_priority_task_queue_tb.sv =====
// ----------------------------------------------------------------------------
// aging_priority_task_queue_tb
// Self-checking bench for the aging priority task queue. A tracker class keeps
// its own copy of the slots and registers, predicts status, id and aged
// priority for every accepted beat and checks each result beat in order.
// Directed corner cases come first, then random phases with varying push mix,
// register settings, idle gaps and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_priority_task_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QD          = 32;
    localparam int CLK_HALF    = 5;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 30;
    localparam int PHASE_BEATS = 50;
    localparam longint PRIO_CAP = 64'd16777215;

    typedef struct packed {
        logic [aptq_pkg::STATUS_W-1:0]   status;
        logic [aptq_pkg::ID_W-1:0]       task_id;
        logic [aptq_pkg::OUT_PRIO_W-1:0] prio;
    } t_queue_outcome;

    // ------------------------------------------------------------------------
    // Tracker: mirrors the queue and holds the outcomes still to arrive.
    // ------------------------------------------------------------------------
    class aged_queue_tracker;
        bit [aptq_pkg::RATE_W-1:0]  rate;
        bit [aptq_pkg::TIME_W-1:0]  now_t;
        bit                         occupied [QD];
        bit [aptq_pkg::ID_W-1:0]    ids      [QD];
        bit [aptq_pkg::BASE_W-1:0]  bases    [QD];
        bit [aptq_pkg::TIME_W-1:0]  born     [QD];
        bit [aptq_pkg::ORDER_W-1:0] ticket   [QD];
        bit [aptq_pkg::ORDER_W-1:0] next_ticket;
        t_queue_outcome             awaited [$];
        int pushes, drops, pops, empties, saturated, clamped, tie_breaks, writes;

        function new();
            rate        = aptq_pkg::AGING_RATE_RST;
            now_t       = '0;
            next_ticket = '0;
            foreach (occupied[s]) occupied[s] = 1'b0;
        endfunction

        function void write_reg(logic [aptq_pkg::CFG_IDX_W-1:0] idx,
                                logic [aptq_pkg::CFG_DAT_W-1:0] data);
            if (idx == aptq_pkg::CFG_AGING_RATE) rate = data[aptq_pkg::RATE_W-1:0];
            else if (idx == aptq_pkg::CFG_NOW_TIME) now_t = data[aptq_pkg::TIME_W-1:0];
            writes++;
        endfunction

        function bit [aptq_pkg::ORDER_W-1:0] age_rank(int s);
            return next_ticket - ticket[s];
        endfunction

        function longint aged_prio(int s);
            return longint'(bases[s]) * 256 +
                   (longint'(now_t) - longint'(born[s])) * longint'(rate);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // work out the outcome of one accepted beat and update the mirror
        function void note_beat(logic op, logic [aptq_pkg::ID_W-1:0] id,
                                logic [aptq_pkg::BASE_W-1:0] base,
                                logic [aptq_pkg::TIME_W-1:0] created);
            t_queue_outcome r;
            int     best;
            longint best_p;
            longint p;
            r      = '{aptq_pkg::STATUS_OK, '0, '0};
            best   = -1;
            best_p = 0;
            if (op == aptq_pkg::OP_PUSH) begin
                for (int s = 0; s < QD; s++)
                    if (!occupied[s] && best < 0) best = s;
                if (best < 0) begin
                    r.status = aptq_pkg::STATUS_FULL;
                    drops++;
                end else begin
                    occupied[best] = 1'b1;
                    ids[best]      = id;
                    bases[best]    = base;
                    born[best]     = created;
                    ticket[best]   = next_ticket;
                    next_ticket++;
                    pushes++;
                end
            end else begin
                for (int s = 0; s < QD; s++) begin
                    if (!occupied[s]) continue;
                    p = aged_prio(s);
                    if (best >= 0 && p == best_p) tie_breaks++;
                    if (best < 0 || p > best_p ||
                        (p == best_p && age_rank(s) > age_rank(best))) begin
                        best   = s;
                        best_p = p;
                    end
                end
                if (best < 0) begin
                    r.status = aptq_pkg::STATUS_EMPTY;
                    empties++;
                end else begin
                    occupied[best] = 1'b0;
                    if (best_p < 0) begin
                        best_p = 0;
                        clamped++;
                    end
                    if (best_p > PRIO_CAP) begin
                        best_p = PRIO_CAP;
                        saturated++;
                    end
                    r.task_id = ids[best];
                    r.prio    = best_p[aptq_pkg::OUT_PRIO_W-1:0];
                    pops++;
                end
            end
            awaited = {awaited, r};
        endfunction

        // empty string when the beat matches the oldest outcome
        function string check_beat(logic [aptq_pkg::STATUS_W-1:0] st,
                                   logic [aptq_pkg::ID_W-1:0] id,
                                   logic [aptq_pkg::OUT_PRIO_W-1:0] pr);
            t_queue_outcome e;
            if (awaited.size() == 0)
                return $sformatf("result beat with nothing awaited: status %0d id %h prio %h",
                                 st, id, pr);
            e = awaited.pop_front();
            if (st !== e.status || id !== e.task_id || pr !== e.prio)
                return $sformatf("status %0d/%0d id %h/%h prio %h/%h (got/exp)",
                                 st, e.status, id, e.task_id, pr, e.prio);
            return "";
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its drive
    // ------------------------------------------------------------------------
    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_cfg_we        = 1'b0;
    logic [aptq_pkg::CFG_IDX_W-1:0]      i_cfg_index     = '0;
    logic [aptq_pkg::CFG_DAT_W-1:0]      i_cfg_data      = '0;
    logic                                i_in_valid      = 1'b0;
    logic                                o_in_ready;
    logic                                i_operation     = aptq_pkg::OP_PUSH;
    logic [aptq_pkg::ID_W-1:0]           i_task_id       = '0;
    logic [aptq_pkg::BASE_W-1:0]         i_base_priority = '0;
    logic [aptq_pkg::TIME_W-1:0]         i_created_time  = '0;
    logic                                o_out_valid;
    logic                                i_out_ready     = 1'b0;
    logic [aptq_pkg::STATUS_W-1:0]       o_status;
    logic [aptq_pkg::ID_W-1:0]           o_out_task_id;
    logic [aptq_pkg::OUT_PRIO_W-1:0]     o_out_priority;

    aged_queue_tracker tracker = new();

    int  mismatches = 0;
    int  holds      = 0;
    int  hold_left  = 0;
    bit  hold_due   = 1'b0;
    bit  calm       = 1'b0;

    aging_priority_task_queue #(.QUEUE_DEPTH(QD)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_task_id       (i_task_id),
        .i_base_priority (i_base_priority),
        .i_created_time  (i_created_time),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_out_task_id   (o_out_task_id),
        .o_out_priority  (o_out_priority)
    );

    always #CLK_HALF i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_due) begin
            hold_due    = 1'b0;
            hold_left   = HOLD_CYCLES;
            holds++;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    // result beats
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            msg = tracker.check_beat(o_status, o_out_task_id, o_out_priority);
            if (msg != "") report_mismatch(msg);
        end
    end

    // offer one beat; valid stays up into the next beat unless a gap is taken
    task automatic send_beat(input logic op, input logic [aptq_pkg::ID_W-1:0] id,
                             input logic [aptq_pkg::BASE_W-1:0] base,
                             input logic [aptq_pkg::TIME_W-1:0] created);
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_task_id       <= id;
        i_base_priority <= base;
        i_created_time  <= created;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        tracker.note_beat(op, id, base, created);
        if (!calm && $urandom_range(0, 99) < 31) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (!calm && $urandom_range(0, 99) < 31);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [aptq_pkg::CFG_DAT_W-1:0] rate_word,
                              input logic [aptq_pkg::CFG_DAT_W-1:0] now_word);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= aptq_pkg::CFG_AGING_RATE;
        i_cfg_data  <= rate_word;
        @(posedge i_clk);
        tracker.write_reg(aptq_pkg::CFG_AGING_RATE, rate_word);
        i_cfg_index <= aptq_pkg::CFG_NOW_TIME;
        i_cfg_data  <= now_word;
        @(posedge i_clk);
        tracker.write_reg(aptq_pkg::CFG_NOW_TIME, now_word);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic pop_beat();
        send_beat(aptq_pkg::OP_POP, aptq_pkg::ID_W'($urandom),
                  aptq_pkg::BASE_W'($urandom), aptq_pkg::TIME_W'($urandom));
    endtask

    task automatic run_phase(input int beats, input int push_pct, input bit narrow);
        logic [aptq_pkg::BASE_W-1:0] base;
        logic [aptq_pkg::TIME_W-1:0] created;
        logic [aptq_pkg::TIME_W-1:0] now_v;
        int                          pick;
        for (int n = 0; n < beats; n++) begin
            if ($urandom_range(0, 99) >= push_pct) begin
                pop_beat();
                continue;
            end
            now_v = tracker.now_t;
            if (narrow) begin
                // few distinct priorities so ties and seniority decide often
                base    = aptq_pkg::BASE_W'($urandom_range(0, 3));
                created = now_v - aptq_pkg::TIME_W'($urandom_range(0, 2));
            end else begin
                pick = $urandom_range(0, 9);
                base = (pick == 0) ? '0 : (pick == 1) ? '1 :
                       aptq_pkg::BASE_W'($urandom_range(0, 1023));
                case ($urandom_range(0, 3))
                    0: created = aptq_pkg::TIME_W'($urandom);
                    1: created = now_v - aptq_pkg::TIME_W'($urandom_range(0, 2000));
                    // created in the future
                    2: created = now_v + aptq_pkg::TIME_W'($urandom_range(0, 64));
                    default: created = now_v - aptq_pkg::TIME_W'($urandom_range(0, 8));
                endcase
            end
            send_beat(aptq_pkg::OP_PUSH, aptq_pkg::ID_W'($urandom), base, created);
        end
    endtask

    initial begin
        logic [aptq_pkg::RATE_W-1:0] rate_v;
        logic [aptq_pkg::TIME_W-1:0] now_v;
        int                          mix;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pop, then extremes at default aging
        pop_beat();
        send_beat(aptq_pkg::OP_PUSH, 16'h0000, 10'd0,    16'h0000);
        send_beat(aptq_pkg::OP_PUSH, 16'hFFFF, 10'd1023, 16'hFFFF);
        send_beat(aptq_pkg::OP_PUSH, 16'h1234, 10'd1023, 16'h0000);
        wait_idle();

        // max aging and max now: saturation and order by aged priority
        set_config(16'hFFFF, 16'hFFFF);
        repeat (4) pop_beat();
        wait_idle();

        // tasks created after now: negative aging term, clamped output
        set_config(16'h00FF, 16'h0000);
        send_beat(aptq_pkg::OP_PUSH, 16'hA000, 10'd0, 16'hFFFF);
        send_beat(aptq_pkg::OP_PUSH, 16'hB000, 10'd0, 16'd100);
        pop_beat();
        pop_beat();
        wait_idle();

        // both above the cap: exact priority still picks the winner
        set_config(16'h00FF, 16'hFFFF);
        send_beat(aptq_pkg::OP_PUSH, 16'hD000, 10'd1000, 16'h0000);
        send_beat(aptq_pkg::OP_PUSH, 16'hC000, 10'd1023, 16'h0000);
        pop_beat();
        pop_beat();
        wait_idle();

        // zero aging: equal priority goes to the earliest inserted
        set_config(16'hAB00, 16'd500);
        send_beat(aptq_pkg::OP_PUSH, 16'h00E0, 10'd5, 16'd10);
        send_beat(aptq_pkg::OP_PUSH, 16'h00F0, 10'd5, 16'd20);
        pop_beat();
        pop_beat();
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       rate_v = '0;
                1:       rate_v = '1;
                2:       rate_v = aptq_pkg::AGING_RATE_RST;
                default: rate_v = aptq_pkg::RATE_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       now_v = '0;
                1:       now_v = '1;
                default: now_v = aptq_pkg::TIME_W'($urandom);
            endcase
            set_config({8'($urandom), rate_v}, now_v);
            calm = (ph == 5);
            if (ph == 9) hold_due = 1'b1;
            mix = (ph % 3 == 0) ? 85 : (ph % 3 == 1) ? 50 : 20;
            run_phase(PHASE_BEATS, mix, (ph % 4 == 3));
            wait_idle();
        end
        calm = 1'b0;

        repeat (QD + 8) @(posedge i_clk);
        if (tracker.pending() != 0)
            report_mismatch($sformatf("%0d results never arrived", tracker.pending()));

        $display("covered %0d pushes, %0d dropped on full, %0d pops, %0d pops on empty",
                 tracker.pushes, tracker.drops, tracker.pops, tracker.empties);
        $display("%0d saturated, %0d clamped at zero, %0d equal-priority compares,",
                 tracker.saturated, tracker.clamped, tracker.tie_breaks);
        $display("%0d reg writes, %0d hold-offs", tracker.writes, holds);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout waiting for the queue");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/aptq_pkg.sv
src/aptq_aging.sv
src/aging_priority_task_queue.sv
sim/aging_priority_task_queue_tb.sv
